// File: hdl/fbc_pkg.sv
`default_nettype none

package fbc_pkg;

  localparam int unsigned NUM_PLANES     = 6;
  localparam int unsigned NUM_CORNERS    = 8;
  localparam int unsigned NORM_FRAC_BITS = 14;
  localparam int unsigned COORD_W        = 16;
  localparam int unsigned HALF_W         = 15;
  localparam int unsigned PROD_W         = 2 * COORD_W;
  // Three products plus the scaled offset plus three corner terms stay below 2^34.
  localparam int unsigned ACC_W          = PROD_W + 4;
  localparam int unsigned CFG_IDX_W      = 3;
  localparam int unsigned CFG_DATA_W     = 64;

  typedef enum logic [0:0] {
    OP_POINT = 1'b0,
    OP_BOX   = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    VIS_OUTSIDE   = 2'd0,
    VIS_PARTIAL   = 2'd1,
    VIS_INSIDE    = 2'd2
  } vis_e;

  typedef struct packed {
    logic signed [COORD_W-1:0] nx;
    logic signed [COORD_W-1:0] ny;
    logic signed [COORD_W-1:0] nz;
    logic signed [COORD_W-1:0] d;
  } plane_t;

endpackage

`default_nettype wire

// File: hdl/fbc_in_if.sv
`default_nettype none

interface fbc_in_if;
  logic                                    valid;
  logic                                    ready;
  fbc_pkg::op_e                            operation;
  logic signed [fbc_pkg::COORD_W-1:0]      x_pos;
  logic signed [fbc_pkg::COORD_W-1:0]      y_pos;
  logic signed [fbc_pkg::COORD_W-1:0]      z_pos;
  logic        [fbc_pkg::HALF_W-1:0]       half_extent;
  logic signed [fbc_pkg::COORD_W-1:0]      top_extent;

  modport source (
    output valid, operation, x_pos, y_pos, z_pos, half_extent, top_extent,
    input  ready
  );

  modport sink (
    input  valid, operation, x_pos, y_pos, z_pos, half_extent, top_extent,
    output ready
  );
endinterface

interface fbc_out_if;
  logic                valid;
  logic                ready;
  fbc_pkg::vis_e       visibility;

  modport source (
    output valid, visibility,
    input  ready
  );

  modport sink (
    input  valid, visibility,
    output ready
  );
endinterface

`default_nettype wire

// File: hdl/frustum_box_classifier.sv
`default_nettype none

// Channel   Dir  Handshake          Payload
// --------  ---  -----------------  ----------------------------------------------------
// in_i      in   valid / ready      operation, x_pos, y_pos, z_pos, half_extent, top_extent
// out_o     out  valid / ready      visibility
// cfg       in   cfg_we_i (no wait) cfg_idx_i (plane 0..5), cfg_data_i (64-bit plane)
//
// Four register stages: products, plane base sums, corner sign flags, verdict.
// One request enters per cycle while the output is not stalled; its result moves through
// the product, base-sum, sign-flag and verdict stages; 42 parallel 16x16 multipliers.
// Each stage holds only while it is full and the stage after it is blocked,
// so bubbles collapse and a stalled output never drops or repeats a request.
// Reset clears all planes (every test then reports outside) and all valid bits.

module frustum_box_classifier (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  input  wire                                  cfg_we_i,
  input  wire  [fbc_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  wire  [fbc_pkg::CFG_DATA_W-1:0]       cfg_data_i,
  fbc_in_if.sink                               in_i,
  fbc_out_if.source                            out_o
);

  localparam int unsigned NP = fbc_pkg::NUM_PLANES;
  localparam int unsigned NC = fbc_pkg::NUM_CORNERS;
  localparam int unsigned PW = fbc_pkg::PROD_W;
  localparam int unsigned AW = fbc_pkg::ACC_W;
  localparam int unsigned CW = fbc_pkg::COORD_W;

  // ---------------------------------------------------------------------------
  // Plane registers
  // ---------------------------------------------------------------------------
  fbc_pkg::plane_t plane_q [NP];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int p = 0; p < NP; p++) begin
        plane_q[p] <= '0;
      end
    end else if (cfg_we_i) begin
      // Drop writes to indexes past the last plane.
      for (int p = 0; p < NP; p++) begin
        if (cfg_idx_i == fbc_pkg::CFG_IDX_W'(p)) begin
          plane_q[p] <= fbc_pkg::plane_t'(cfg_data_i);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage enables: a stage loads when empty or when the next stage loads.
  // ---------------------------------------------------------------------------
  logic v1_q, v2_q, v3_q, v4_q;
  logic en1, en2, en3, en4;

  assign en4 = !v4_q || out_o.ready;
  assign en3 = !v3_q || en4;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;

  assign in_i.ready = en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_i.valid;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: per-plane products. Corners are the center moved by +-h in x and z and
  // by -h, 0 or +top in y, so n.corner splits into n.center plus scaled extent terms.
  // ---------------------------------------------------------------------------
  logic signed [CW-1:0] half_s;
  assign half_s = $signed({1'b0, in_i.half_extent});

  fbc_pkg::op_e          op1_q;
  logic signed [PW-1:0]  mx1_q  [NP];  // nx * x
  logic signed [PW-1:0]  my1_q  [NP];  // ny * y
  logic signed [PW-1:0]  mz1_q  [NP];  // nz * z
  logic signed [PW-1:0]  off1_q [NP];  // d scaled to the product format
  logic signed [PW-1:0]  hx1_q  [NP];  // nx * h
  logic signed [PW-1:0]  hz1_q  [NP];  // nz * h
  logic signed [PW-1:0]  hy1_q  [NP];  // ny * h
  logic signed [PW-1:0]  ty1_q  [NP];  // ny * top

  always_ff @(posedge clk_i) begin
    if (en1) begin
      op1_q <= in_i.operation;
      for (int p = 0; p < NP; p++) begin
        mx1_q[p]  <= plane_q[p].nx * in_i.x_pos;
        my1_q[p]  <= plane_q[p].ny * in_i.y_pos;
        mz1_q[p]  <= plane_q[p].nz * in_i.z_pos;
        off1_q[p] <= PW'($signed({plane_q[p].d, {fbc_pkg::NORM_FRAC_BITS{1'b0}}}));
        hx1_q[p]  <= plane_q[p].nx * half_s;
        hz1_q[p]  <= plane_q[p].nz * half_s;
        hy1_q[p]  <= plane_q[p].ny * half_s;
        ty1_q[p]  <= plane_q[p].ny * in_i.top_extent;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: plane value at the reference point; pass extent terms along.
  // ---------------------------------------------------------------------------
  fbc_pkg::op_e          op2_q;
  logic signed [AW-1:0]  base2_q [NP];
  logic signed [PW-1:0]  hx2_q   [NP];
  logic signed [PW-1:0]  hz2_q   [NP];
  logic signed [PW-1:0]  hy2_q   [NP];
  logic signed [PW-1:0]  ty2_q   [NP];

  always_ff @(posedge clk_i) begin
    if (en2) begin
      op2_q <= op1_q;
      for (int p = 0; p < NP; p++) begin
        base2_q[p] <= AW'(mx1_q[p]) + AW'(my1_q[p]) + AW'(mz1_q[p]) + AW'(off1_q[p]);
        hx2_q[p]   <= hx1_q[p];
        hz2_q[p]   <= hz1_q[p];
        hy2_q[p]   <= hy1_q[p];
        ty2_q[p]   <= ty1_q[p];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: sign flags for the point and for all eight corners per plane.
  // Corner bit 0 picks x+h, bit 2 picks z+h, bit 1 picks y+top; otherwise
  // lower-z corners sit at y-h and upper-z corners at y.
  // ---------------------------------------------------------------------------
  logic signed [AW-1:0] corner_val [NP][NC];

  always_comb begin
    for (int p = 0; p < NP; p++) begin
      for (int c = 0; c < NC; c++) begin
        corner_val[p][c] = base2_q[p]
          + (c[0] ? AW'(hx2_q[p]) : -AW'(hx2_q[p]))
          + (c[2] ? AW'(hz2_q[p]) : -AW'(hz2_q[p]))
          + (c[1] ? AW'(ty2_q[p]) : (c[2] ? AW'(0) : -AW'(hy2_q[p])));
      end
    end
  end

  fbc_pkg::op_e    op3_q;
  logic [NP-1:0]   pt3_q;
  logic [NC-1:0]   cor3_q [NP];

  always_ff @(posedge clk_i) begin
    if (en3) begin
      op3_q <= op2_q;
      for (int p = 0; p < NP; p++) begin
        pt3_q[p] <= (base2_q[p] > 0);
        for (int c = 0; c < NC; c++) begin
          cor3_q[p][c] <= (corner_val[p][c] > 0);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 4: verdict and output register.
  // ---------------------------------------------------------------------------
  logic          box_out;
  logic          box_full;
  fbc_pkg::vis_e vis_d;

  always_comb begin
    box_out  = 1'b0;
    box_full = 1'b1;
    for (int p = 0; p < NP; p++) begin
      if (cor3_q[p] == '0) box_out = 1'b1;
      if (cor3_q[p] != '1) box_full = 1'b0;
    end
    if (op3_q == fbc_pkg::OP_POINT) begin
      vis_d = (&pt3_q) ? fbc_pkg::VIS_PARTIAL : fbc_pkg::VIS_OUTSIDE;
    end else if (box_out) begin
      vis_d = fbc_pkg::VIS_OUTSIDE;
    end else if (box_full) begin
      vis_d = fbc_pkg::VIS_INSIDE;
    end else begin
      vis_d = fbc_pkg::VIS_PARTIAL;
    end
  end

  fbc_pkg::op_e  op4_q;
  fbc_pkg::vis_e vis4_q;

  always_ff @(posedge clk_i) begin
    if (en4) begin
      op4_q  <= op3_q;
      vis4_q <= vis_d;
    end
  end

  assign out_o.valid      = v4_q;
  assign out_o.visibility = vis4_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_point_never_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v4_q && op4_q == fbc_pkg::OP_POINT) |-> (vis4_q != fbc_pkg::VIS_INSIDE))
    else $error("point test reported fully inside");

  a_ready_when_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !v4_q |-> in_i.ready)
    else $error("input blocked while output stage is empty");

  a_box_culled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v3_q && en4 && op3_q == fbc_pkg::OP_BOX && box_out)
      |=> (vis4_q == fbc_pkg::VIS_OUTSIDE))
    else $error("box with a fully rejecting plane not reported outside");

  a_mid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v2_q && !en3) |=> (v2_q && $stable(base2_q[0])))
    else $error("stalled stage 2 lost its request");

endmodule

`default_nettype wire
